/* hdl/stl_pkg.sv */
`timescale 1ns / 1ps

package stl_pkg;

	// default widths
	localparam int OFFSET_WIDTH_DEF = 32;
	localparam int LENGTH_WIDTH_DEF = 16;

	// results a single byte can produce
	localparam int MAX_TOKENS = 4;

	// configuration register indexes
	localparam logic [2:0] REG_NEWLINE  = 3'd0;
	localparam logic [2:0] REG_TRIPLE   = 3'd1;
	localparam logic [2:0] REG_LINECMT  = 3'd2;
	localparam logic [2:0] REG_BLOCKCMT = 3'd3;
	localparam logic [2:0] REG_EMBED    = 3'd4;

	typedef struct packed {
		logic newline_tokens_on;
		logic triple_quote_strings_on;
		logic line_comments_on;
		logic block_comments_on;
		logic string_embeds_on;
	} cfg_t;

	// token kinds
	localparam logic [5:0] K_EOF        = 6'd0;
	localparam logic [5:0] K_INVALID    = 6'd1;
	localparam logic [5:0] K_WS         = 6'd2;
	localparam logic [5:0] K_NEWLINE    = 6'd3;
	localparam logic [5:0] K_LINECMT    = 6'd4;
	localparam logic [5:0] K_BLOCKCMT   = 6'd5;
	localparam logic [5:0] K_IDENT      = 6'd6;
	localparam logic [5:0] K_NUMBER     = 6'd7;
	localparam logic [5:0] K_BEGSTR     = 6'd8;
	localparam logic [5:0] K_BEGML      = 6'd9;
	localparam logic [5:0] K_STRLIT     = 6'd10;
	localparam logic [5:0] K_BEGEMBED   = 6'd11;
	localparam logic [5:0] K_ENDSTR     = 6'd12;
	localparam logic [5:0] K_OPENCURLY  = 6'd13;
	localparam logic [5:0] K_CLOSECURLY = 6'd14;
	localparam logic [5:0] K_OPENPAREN  = 6'd15;
	localparam logic [5:0] K_CLOSEPAREN = 6'd16;
	localparam logic [5:0] K_SEMICOLON  = 6'd20;
	localparam logic [5:0] K_DOT        = 6'd21;
	localparam logic [5:0] K_COMMA      = 6'd22;
	localparam logic [5:0] K_EQUAL      = 6'd23;
	localparam logic [5:0] K_SLASHEQ    = 6'd24;
	localparam logic [5:0] K_LT         = 6'd25;
	localparam logic [5:0] K_LE         = 6'd26;
	localparam logic [5:0] K_GT         = 6'd27;
	localparam logic [5:0] K_GE         = 6'd28;
	localparam logic [5:0] K_DBLEQ      = 6'd29;
	localparam logic [5:0] K_PLUS       = 6'd30;
	localparam logic [5:0] K_MINUS      = 6'd31;
	localparam logic [5:0] K_ASTERISK   = 6'd32;
	localparam logic [5:0] K_SLASH      = 6'd33;
	localparam logic [5:0] K_PERCENT    = 6'd34;
	localparam logic [5:0] K_BANG       = 6'd35;
	localparam logic [5:0] K_TILDE      = 6'd36;
	localparam logic [5:0] K_BAR        = 6'd37;
	localparam logic [5:0] K_DBLBAR     = 6'd38;
	localparam logic [5:0] K_AMP        = 6'd39;
	localparam logic [5:0] K_DBLAMP     = 6'd40;

	// error codes
	localparam logic [1:0] E_NONE      = 2'd0;
	localparam logic [1:0] E_EOF_STR   = 2'd1;
	localparam logic [1:0] E_NL_STR    = 2'd2;
	localparam logic [1:0] E_EOF_BLOCK = 2'd3;

	// characters
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LCURLY  = 8'h7B;
	localparam logic [7:0] CH_BAR     = 8'h7C;
	localparam logic [7:0] CH_RCURLY  = 8'h7D;
	localparam logic [7:0] CH_TILDE   = 8'h7E;

	// lexer modes
	typedef enum logic [17:0] {
		M_IDLE   = 18'h00001,
		M_IDENT  = 18'h00002,
		M_NUM    = 18'h00004,
		M_WS     = 18'h00008,
		M_SLASH  = 18'h00010,
		M_LINE   = 18'h00020,
		M_BLOCK  = 18'h00040,
		M_BSTAR  = 18'h00080,
		M_EQ     = 18'h00100,
		M_LT     = 18'h00200,
		M_GT     = 18'h00400,
		M_BAR    = 18'h00800,
		M_AMP    = 18'h01000,
		M_OPENQ  = 18'h02000,
		M_STR    = 18'h04000,
		M_ESC    = 18'h08000,
		M_DOLLAR = 18'h10000,
		M_CLOSEQ = 18'h20000
	} mode_t;

	// string nesting
	typedef enum logic [1:0] {
		S_NONE  = 2'd0,
		S_IN    = 2'd1,
		S_EMBED = 2'd2
	} smode_t;

	function automatic logic is_letter(logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			b == CH_UNDER || b[7];
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	// single byte tokens that finish at once
	function automatic logic [5:0] punct_kind(logic [7:0] b);
		logic [5:0] k;
		case (b)
			CH_SEMI:    k = K_SEMICOLON;
			CH_PERCENT: k = K_PERCENT;
			CH_BANG:    k = K_BANG;
			CH_TILDE:   k = K_TILDE;
			CH_LCURLY:  k = K_OPENCURLY;
			CH_LPAREN:  k = K_OPENPAREN;
			CH_RPAREN:  k = K_CLOSEPAREN;
			CH_DOT:     k = K_DOT;
			CH_COMMA:   k = K_COMMA;
			CH_PLUS:    k = K_PLUS;
			CH_MINUS:   k = K_MINUS;
			CH_STAR:    k = K_ASTERISK;
			default:    k = K_INVALID;
		endcase
		return k;
	endfunction

endpackage

/* hdl/stl_front.sv */
`timescale 1ns / 1ps

module stl_front #(
	parameter int OFFSET_WIDTH = stl_pkg::OFFSET_WIDTH_DEF,
	parameter int LENGTH_WIDTH = stl_pkg::LENGTH_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  stl_pkg::cfg_t                               cfg,
	input  logic                                        in_valid,
	output logic                                        in_stall,
	input  logic [7:0]                                  in_byte,
	input  logic                                        end_of_input,
	input  logic                                        q_full,
	output logic                                        q_push,
	output logic [4*(OFFSET_WIDTH+LENGTH_WIDTH+8)+2:0]  q_data
);

	localparam int OW = OFFSET_WIDTH;
	localparam int LW = LENGTH_WIDTH;

	typedef struct packed {
		logic [5:0]    kind;
		logic [OW-1:0] start;
		logic [LW-1:0] len;
		logic [1:0]    err;
	} tok_t;

	typedef struct packed {
		logic [2:0]      cnt;
		tok_t [3:0]      tok;
	} bnd_t;

	stl_pkg::mode_t  mode_q, mode_n;
	stl_pkg::smode_t smode_q, smode_n;
	logic            ml_q, ml_n;
	logic [1:0]      qc_q, qc_n;
	logic [OW-1:0]   ts_q, ts_n;
	logic [OW-1:0]   pos_q, pos_n;
	logic [LW-1:0]   lc_q, lc_n;
	bnd_t            bnd;
	logic            accept;

	function automatic logic [LW-1:0] sat_add(logic [LW-1:0] a, logic [1:0] n);
		logic [LW:0] s;
		s = {1'b0, a} + (LW+1)'(n);
		return s[LW] ? {LW{1'b1}} : s[LW-1:0];
	endfunction

	function automatic bnd_t emit(bnd_t bd, logic [5:0] k, logic [OW-1:0] st,
		logic [LW-1:0] ln, logic [1:0] er);
		if (bd.cnt < 3'd4) begin
			bd.tok[bd.cnt[1:0]].kind  = k;
			bd.tok[bd.cnt[1:0]].start = st;
			bd.tok[bd.cnt[1:0]].len   = ln;
			bd.tok[bd.cnt[1:0]].err   = er;
			bd.cnt = bd.cnt + 3'd1;
		end
		return bd;
	endfunction

	// token recognition for one byte, up to four re-lex passes
	always_comb begin
		bnd_t            bd;
		stl_pkg::mode_t  m;
		stl_pkg::smode_t sm;
		logic            ml;
		logic [1:0]      qc;
		logic [OW-1:0]   ts;
		logic [OW-1:0]   pos;
		logic [LW-1:0]   lc;
		logic            done;
		logic [7:0]      b;
		bd   = '0;
		m    = mode_q;
		sm   = smode_q;
		ml   = ml_q;
		qc   = qc_q;
		ts   = ts_q;
		pos  = pos_q;
		lc   = lc_q;
		done = 1'b0;
		b    = in_byte;
		if (end_of_input) begin
			// flush pending token, then end of file
			case (m)
				stl_pkg::M_IDENT: bd = emit(bd, stl_pkg::K_IDENT, ts, lc, stl_pkg::E_NONE);
				stl_pkg::M_NUM:   bd = emit(bd, stl_pkg::K_NUMBER, ts, lc, stl_pkg::E_NONE);
				stl_pkg::M_WS:    bd = emit(bd, stl_pkg::K_WS, ts, lc, stl_pkg::E_NONE);
				stl_pkg::M_LINE:  bd = emit(bd, stl_pkg::K_LINECMT, ts, lc, stl_pkg::E_NONE);
				stl_pkg::M_BLOCK, stl_pkg::M_BSTAR:
					bd = emit(bd, stl_pkg::K_BLOCKCMT, ts, lc, stl_pkg::E_EOF_BLOCK);
				stl_pkg::M_SLASH: bd = emit(bd, stl_pkg::K_SLASH, ts, LW'(1), stl_pkg::E_NONE);
				stl_pkg::M_EQ:    bd = emit(bd, stl_pkg::K_EQUAL, ts, LW'(1), stl_pkg::E_NONE);
				stl_pkg::M_LT:    bd = emit(bd, stl_pkg::K_LT, ts, LW'(1), stl_pkg::E_NONE);
				stl_pkg::M_GT:    bd = emit(bd, stl_pkg::K_GT, ts, LW'(1), stl_pkg::E_NONE);
				stl_pkg::M_BAR:   bd = emit(bd, stl_pkg::K_BAR, ts, LW'(1), stl_pkg::E_NONE);
				stl_pkg::M_AMP:   bd = emit(bd, stl_pkg::K_AMP, ts, LW'(1), stl_pkg::E_NONE);
				stl_pkg::M_OPENQ: begin
					if (qc == 2'd2) begin
						bd = emit(bd, stl_pkg::K_BEGSTR, ts, LW'(1), stl_pkg::E_NONE);
						bd = emit(bd, stl_pkg::K_ENDSTR, ts + OW'(1), LW'(1), stl_pkg::E_NONE);
					end else begin
						if (qc == 2'd1)
							bd = emit(bd, stl_pkg::K_BEGSTR, ts, LW'(1), stl_pkg::E_NONE);
						else
							bd = emit(bd, stl_pkg::K_BEGML, ts, LW'(3), stl_pkg::E_NONE);
						bd = emit(bd, stl_pkg::K_ENDSTR, pos, '0, stl_pkg::E_EOF_STR);
					end
				end
				stl_pkg::M_STR: begin
					if (lc != '0) bd = emit(bd, stl_pkg::K_STRLIT, ts, lc, stl_pkg::E_NONE);
					bd = emit(bd, stl_pkg::K_ENDSTR, pos, '0, stl_pkg::E_EOF_STR);
				end
				stl_pkg::M_ESC: begin
					if (lc > LW'(1)) bd = emit(bd, stl_pkg::K_STRLIT, ts, lc, stl_pkg::E_NONE);
					bd = emit(bd, stl_pkg::K_ENDSTR, pos, '0, stl_pkg::E_EOF_STR);
				end
				stl_pkg::M_DOLLAR: begin
					lc = sat_add(lc, 2'd1);
					bd = emit(bd, stl_pkg::K_STRLIT, ts, lc, stl_pkg::E_NONE);
					bd = emit(bd, stl_pkg::K_ENDSTR, pos, '0, stl_pkg::E_EOF_STR);
				end
				stl_pkg::M_CLOSEQ: begin
					lc = sat_add(lc, qc);
					if (lc != '0) bd = emit(bd, stl_pkg::K_STRLIT, ts, lc, stl_pkg::E_NONE);
					bd = emit(bd, stl_pkg::K_ENDSTR, pos, '0, stl_pkg::E_EOF_STR);
				end
				default: ;
			endcase
			bd = emit(bd, stl_pkg::K_EOF, pos, '0, stl_pkg::E_NONE);
			m  = stl_pkg::M_IDLE;
			sm = stl_pkg::S_NONE;
			ml = 1'b0;
			qc = 2'd0;
			ts = '0;
			lc = '0;
			pos_n = '0;
		end else begin
			pos_n = pos + OW'(1);
			for (int it = 0; it < 4; it++) begin
				if (!done) begin
					case (m)
						stl_pkg::M_IDLE: begin
							done = 1'b1;
							ts = pos;
							lc = LW'(1);
							if (stl_pkg::is_letter(b)) m = stl_pkg::M_IDENT;
							else if (stl_pkg::is_digit(b)) m = stl_pkg::M_NUM;
							else if (b <= stl_pkg::CH_SPACE) begin
								if (b == stl_pkg::CH_NL && cfg.newline_tokens_on)
									bd = emit(bd, stl_pkg::K_NEWLINE, pos, LW'(1),
										stl_pkg::E_NONE);
								else m = stl_pkg::M_WS;
							end else begin
								case (b)
									stl_pkg::CH_QUOTE: begin
										if (cfg.triple_quote_strings_on) begin
											m = stl_pkg::M_OPENQ;
											qc = 2'd1;
										end else begin
											bd = emit(bd, stl_pkg::K_BEGSTR, pos, LW'(1),
												stl_pkg::E_NONE);
											sm = stl_pkg::S_IN;
											ml = 1'b0;
											m = stl_pkg::M_STR;
											lc = '0;
											qc = 2'd0;
										end
									end
									stl_pkg::CH_SLASH: m = stl_pkg::M_SLASH;
									stl_pkg::CH_EQ:    m = stl_pkg::M_EQ;
									stl_pkg::CH_LT:    m = stl_pkg::M_LT;
									stl_pkg::CH_GT:    m = stl_pkg::M_GT;
									stl_pkg::CH_BAR:   m = stl_pkg::M_BAR;
									stl_pkg::CH_AMP:   m = stl_pkg::M_AMP;
									stl_pkg::CH_RCURLY: begin
										bd = emit(bd, stl_pkg::K_CLOSECURLY, pos, LW'(1),
											stl_pkg::E_NONE);
										// closing an embed returns to the string
										if (sm == stl_pkg::S_EMBED) begin
											sm = stl_pkg::S_IN;
											m = stl_pkg::M_STR;
											lc = '0;
											qc = 2'd0;
										end
									end
									default: bd = emit(bd, stl_pkg::punct_kind(b), pos,
										LW'(1), stl_pkg::E_NONE);
								endcase
							end
						end
						stl_pkg::M_IDENT: begin
							if (stl_pkg::is_letter(b) || stl_pkg::is_digit(b)) begin
								lc = sat_add(lc, 2'd1);
								done = 1'b1;
							end else begin
								bd = emit(bd, stl_pkg::K_IDENT, ts, lc, stl_pkg::E_NONE);
								m = stl_pkg::M_IDLE;
							end
						end
						stl_pkg::M_NUM: begin
							if (stl_pkg::is_digit(b)) begin
								lc = sat_add(lc, 2'd1);
								done = 1'b1;
							end else begin
								bd = emit(bd, stl_pkg::K_NUMBER, ts, lc, stl_pkg::E_NONE);
								m = stl_pkg::M_IDLE;
							end
						end
						stl_pkg::M_WS: begin
							if (b <= stl_pkg::CH_SPACE &&
								!(b == stl_pkg::CH_NL && cfg.newline_tokens_on)) begin
								lc = sat_add(lc, 2'd1);
								done = 1'b1;
							end else begin
								bd = emit(bd, stl_pkg::K_WS, ts, lc, stl_pkg::E_NONE);
								m = stl_pkg::M_IDLE;
							end
						end
						stl_pkg::M_SLASH: begin
							if (b == stl_pkg::CH_SLASH && cfg.line_comments_on) begin
								lc = sat_add(lc, 2'd1);
								m = stl_pkg::M_LINE;
								done = 1'b1;
							end else if (b == stl_pkg::CH_STAR && cfg.block_comments_on) begin
								lc = sat_add(lc, 2'd1);
								m = stl_pkg::M_BLOCK;
								done = 1'b1;
							end else begin
								m = stl_pkg::M_IDLE;
								if (b == stl_pkg::CH_EQ) begin
									bd = emit(bd, stl_pkg::K_SLASHEQ, ts, LW'(2),
										stl_pkg::E_NONE);
									done = 1'b1;
								end else begin
									bd = emit(bd, stl_pkg::K_SLASH, ts, LW'(1),
										stl_pkg::E_NONE);
								end
							end
						end
						stl_pkg::M_LINE: begin
							if (b != stl_pkg::CH_NL) begin
								lc = sat_add(lc, 2'd1);
								done = 1'b1;
							end else begin
								bd = emit(bd, stl_pkg::K_LINECMT, ts, lc, stl_pkg::E_NONE);
								m = stl_pkg::M_IDLE;
							end
						end
						stl_pkg::M_BLOCK: begin
							lc = sat_add(lc, 2'd1);
							if (b == stl_pkg::CH_STAR) m = stl_pkg::M_BSTAR;
							done = 1'b1;
						end
						stl_pkg::M_BSTAR: begin
							lc = sat_add(lc, 2'd1);
							if (b == stl_pkg::CH_SLASH) begin
								bd = emit(bd, stl_pkg::K_BLOCKCMT, ts, lc, stl_pkg::E_NONE);
								m = stl_pkg::M_IDLE;
							end else if (b != stl_pkg::CH_STAR) m = stl_pkg::M_BLOCK;
							done = 1'b1;
						end
						stl_pkg::M_EQ, stl_pkg::M_LT, stl_pkg::M_GT,
						stl_pkg::M_BAR, stl_pkg::M_AMP: begin
							logic [7:0] sec;
							logic [5:0] kd, ks;
							case (m)
								stl_pkg::M_EQ: begin
									sec = stl_pkg::CH_EQ; kd = stl_pkg::K_DBLEQ;
									ks = stl_pkg::K_EQUAL;
								end
								stl_pkg::M_LT: begin
									sec = stl_pkg::CH_EQ; kd = stl_pkg::K_LE;
									ks = stl_pkg::K_LT;
								end
								stl_pkg::M_GT: begin
									sec = stl_pkg::CH_EQ; kd = stl_pkg::K_GE;
									ks = stl_pkg::K_GT;
								end
								stl_pkg::M_BAR: begin
									sec = stl_pkg::CH_BAR; kd = stl_pkg::K_DBLBAR;
									ks = stl_pkg::K_BAR;
								end
								default: begin
									sec = stl_pkg::CH_AMP; kd = stl_pkg::K_DBLAMP;
									ks = stl_pkg::K_AMP;
								end
							endcase
							m = stl_pkg::M_IDLE;
							if (b == sec) begin
								bd = emit(bd, kd, ts, LW'(2), stl_pkg::E_NONE);
								done = 1'b1;
							end else begin
								bd = emit(bd, ks, ts, LW'(1), stl_pkg::E_NONE);
							end
						end
						stl_pkg::M_OPENQ: begin
							if (qc == 2'd3) begin
								// triple quote opens a multiline string
								bd = emit(bd, stl_pkg::K_BEGML, ts,
									(b == stl_pkg::CH_NL) ? LW'(4) : LW'(3), stl_pkg::E_NONE);
								sm = stl_pkg::S_IN;
								ml = 1'b1;
								m = stl_pkg::M_STR;
								lc = '0;
								qc = 2'd0;
								if (b == stl_pkg::CH_NL) done = 1'b1;
							end else if (b == stl_pkg::CH_QUOTE) begin
								qc = qc + 2'd1;
								done = 1'b1;
							end else if (qc == 2'd1) begin
								bd = emit(bd, stl_pkg::K_BEGSTR, ts, LW'(1), stl_pkg::E_NONE);
								sm = stl_pkg::S_IN;
								ml = 1'b0;
								m = stl_pkg::M_STR;
								lc = '0;
								qc = 2'd0;
							end else begin
								// two quotes: empty single-line string
								bd = emit(bd, stl_pkg::K_BEGSTR, ts, LW'(1), stl_pkg::E_NONE);
								bd = emit(bd, stl_pkg::K_ENDSTR, ts + OW'(1), LW'(1),
									stl_pkg::E_NONE);
								ts = ts + OW'(1);
								sm = stl_pkg::S_NONE;
								ml = 1'b0;
								m = stl_pkg::M_IDLE;
								lc = '0;
								qc = 2'd0;
							end
						end
						stl_pkg::M_STR: begin
							if (lc == '0) ts = pos;
							done = 1'b1;
							if (b == stl_pkg::CH_BSLASH) begin
								lc = sat_add(lc, 2'd1);
								m = stl_pkg::M_ESC;
							end else if (b == stl_pkg::CH_QUOTE) begin
								if (ml) begin
									m = stl_pkg::M_CLOSEQ;
									qc = 2'd1;
								end else begin
									if (lc != '0)
										bd = emit(bd, stl_pkg::K_STRLIT, ts, lc, stl_pkg::E_NONE);
									bd = emit(bd, stl_pkg::K_ENDSTR, pos, LW'(1),
										stl_pkg::E_NONE);
									sm = stl_pkg::S_NONE;
									m = stl_pkg::M_IDLE;
									lc = '0;
									qc = 2'd0;
								end
							end else if (b == stl_pkg::CH_DOLLAR && cfg.string_embeds_on) begin
								m = stl_pkg::M_DOLLAR;
							end else if (b == stl_pkg::CH_NL && !ml) begin
								// newline ends the string, then is lexed again
								if (lc != '0)
									bd = emit(bd, stl_pkg::K_STRLIT, ts, lc, stl_pkg::E_NONE);
								bd = emit(bd, stl_pkg::K_ENDSTR, pos, '0, stl_pkg::E_NL_STR);
								sm = stl_pkg::S_NONE;
								m = stl_pkg::M_IDLE;
								lc = '0;
								qc = 2'd0;
								done = 1'b0;
							end else begin
								lc = sat_add(lc, 2'd1);
							end
						end
						stl_pkg::M_ESC: begin
							lc = sat_add(lc, 2'd1);
							m = stl_pkg::M_STR;
							done = 1'b1;
						end
						stl_pkg::M_DOLLAR: begin
							if (b == stl_pkg::CH_LCURLY) begin
								if (lc != '0)
									bd = emit(bd, stl_pkg::K_STRLIT, ts, lc, stl_pkg::E_NONE);
								bd = emit(bd, stl_pkg::K_BEGEMBED, pos - OW'(1), LW'(2),
									stl_pkg::E_NONE);
								sm = stl_pkg::S_EMBED;
								m = stl_pkg::M_IDLE;
								lc = '0;
								done = 1'b1;
							end else begin
								lc = sat_add(lc, 2'd1);
								m = stl_pkg::M_STR;
							end
						end
						stl_pkg::M_CLOSEQ: begin
							if (b == stl_pkg::CH_QUOTE) begin
								done = 1'b1;
								if (qc == 2'd1) qc = 2'd2;
								else begin
									if (lc != '0)
										bd = emit(bd, stl_pkg::K_STRLIT, ts, lc, stl_pkg::E_NONE);
									bd = emit(bd, stl_pkg::K_ENDSTR, pos - OW'(2), LW'(3),
										stl_pkg::E_NONE);
									sm = stl_pkg::S_NONE;
									m = stl_pkg::M_IDLE;
									lc = '0;
									qc = 2'd0;
								end
							end else begin
								lc = sat_add(lc, qc);
								qc = 2'd0;
								m = stl_pkg::M_STR;
							end
						end
						default: m = stl_pkg::M_IDLE;
					endcase
				end
			end
		end
		mode_n  = m;
		smode_n = sm;
		ml_n    = ml;
		qc_n    = qc;
		ts_n    = ts;
		lc_n    = lc;
		bnd     = bd;
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && (bnd.cnt != 3'd0);
	assign q_data   = bnd;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stl_pkg::M_IDLE;
			smode_q <= stl_pkg::S_NONE;
			ml_q    <= 1'b0;
			qc_q    <= 2'd0;
			ts_q    <= '0;
			pos_q   <= '0;
			lc_q    <= '0;
		end else if (accept) begin
			mode_q  <= mode_n;
			smode_q <= smode_n;
			ml_q    <= ml_n;
			qc_q    <= qc_n;
			ts_q    <= ts_n;
			pos_q   <= pos_n;
			lc_q    <= lc_n;
		end
	end

endmodule

/* hdl/stl_back.sv */
`timescale 1ns / 1ps

module stl_back #(
	parameter int OFFSET_WIDTH = stl_pkg::OFFSET_WIDTH_DEF,
	parameter int LENGTH_WIDTH = stl_pkg::LENGTH_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        q_push,
	input  logic [4*(OFFSET_WIDTH+LENGTH_WIDTH+8)+2:0]  q_data,
	output logic                                        q_full,
	output logic                                        out_valid,
	input  logic                                        out_stall,
	output logic [5:0]                                  token_kind,
	output logic [OFFSET_WIDTH-1:0]                     start_offset,
	output logic [LENGTH_WIDTH-1:0]                     token_length,
	output logic [1:0]                                  error_code,
	output logic                                        last_result
);

	localparam int OW = OFFSET_WIDTH;
	localparam int LW = LENGTH_WIDTH;

	typedef struct packed {
		logic [5:0]    kind;
		logic [OW-1:0] start;
		logic [LW-1:0] len;
		logic [1:0]    err;
	} tok_t;

	typedef struct packed {
		logic [2:0]      cnt;
		tok_t [3:0]      tok;
	} bnd_t;

	bnd_t       mem_q [4];
	logic [1:0] wp_q, rp_q, sel_q;
	logic [2:0] cnt_q;
	bnd_t       head;
	tok_t       cur;
	logic       pop;

	assign head        = mem_q[rp_q];
	assign cur         = head.tok[sel_q];
	assign q_full      = (cnt_q == 3'd4);
	assign out_valid   = (cnt_q != 3'd0);
	assign last_result = (sel_q == 2'(head.cnt - 3'd1));
	assign token_kind   = cur.kind;
	assign start_offset = cur.start;
	assign token_length = cur.len;
	assign error_code   = cur.err;
	assign pop = out_valid && !out_stall && last_result;

	// bundle storage
	always_ff @(posedge clk) begin
		if (q_push) mem_q[wp_q] <= q_data;
	end

	// queue pointers and token select within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			sel_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (q_push) wp_q <= wp_q + 2'd1;
			if (out_valid && !out_stall) begin
				if (last_result) begin
					sel_q <= 2'd0;
					rp_q  <= rp_q + 2'd1;
				end else begin
					sel_q <= sel_q + 2'd1;
				end
			end
			cnt_q <= cnt_q + {2'd0, q_push} - {2'd0, pop};
		end
	end

endmodule

/* hdl/source_text_lexer.sv */
`timescale 1ns / 1ps

// Streaming source lexer. One source byte (or the end marker) is taken per
// cycle whenever the four-bundle token queue has room; the byte is
// classified in the same cycle and the up to four tokens it completes go
// into the queue as one bundle. Tokens leave one per cycle while out_stall
// is low, so the output side sets the sustained rate: the tokens of a bundle
// leave one by one, and the input stalls only once the queue is full.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and 16 and may
// be written only while the lexer is idle.
module source_text_lexer #(
	parameter int OFFSET_WIDTH = stl_pkg::OFFSET_WIDTH_DEF,
	parameter int LENGTH_WIDTH = stl_pkg::LENGTH_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               in_byte,
	input  logic                     end_of_input,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [5:0]               token_kind,
	output logic [OFFSET_WIDTH-1:0]  start_offset,
	output logic [LENGTH_WIDTH-1:0]  token_length,
	output logic [1:0]               error_code,
	output logic                     last_result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [4:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	stl_pkg::cfg_t cfg_q;
	logic          q_push, q_full;
	logic [4*(OFFSET_WIDTH+LENGTH_WIDTH+8)+2:0] q_data;

	assign pready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				stl_pkg::REG_NEWLINE:  cfg_q.newline_tokens_on       <= pwdata[0];
				stl_pkg::REG_TRIPLE:   cfg_q.triple_quote_strings_on <= pwdata[0];
				stl_pkg::REG_LINECMT:  cfg_q.line_comments_on        <= pwdata[0];
				stl_pkg::REG_BLOCKCMT: cfg_q.block_comments_on       <= pwdata[0];
				stl_pkg::REG_EMBED:    cfg_q.string_embeds_on        <= pwdata[0];
				default: ;
			endcase
		end
	end

	// configuration reads
	always_comb begin
		case (paddr[4:2])
			stl_pkg::REG_NEWLINE:  prdata = {31'd0, cfg_q.newline_tokens_on};
			stl_pkg::REG_TRIPLE:   prdata = {31'd0, cfg_q.triple_quote_strings_on};
			stl_pkg::REG_LINECMT:  prdata = {31'd0, cfg_q.line_comments_on};
			stl_pkg::REG_BLOCKCMT: prdata = {31'd0, cfg_q.block_comments_on};
			stl_pkg::REG_EMBED:    prdata = {31'd0, cfg_q.string_embeds_on};
			default:               prdata = 32'd0;
		endcase
	end

	stl_front #(
		.OFFSET_WIDTH(OFFSET_WIDTH),
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_data)
	);

	stl_back #(
		.OFFSET_WIDTH(OFFSET_WIDTH),
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_push       (q_push),
		.q_data       (q_data),
		.q_full       (q_full),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.start_offset (start_offset),
		.token_length (token_length),
		.error_code   (error_code),
		.last_result  (last_result)
	);

endmodule
